### rtl/core/wrpp_pkg.sv
// ----------------------------------------------------------------------------
// wrpp_pkg
// Shared types, constants and match tables for the wifi response prefix parser.
// ----------------------------------------------------------------------------
package wrpp_pkg;

  // Number of bytes one frame capture can hold; the capture index saturates at CaptureDepth - 1.
  localparam int unsigned CaptureDepth = 256;
  localparam int unsigned CountW       = $clog2(CaptureDepth + 1);

  localparam logic [7:0] LineFeed   = 8'h0A;
  localparam logic [7:0] CharOpen   = 8'h7B;  // '{'
  localparam logic [7:0] CharClose  = 8'h7D;  // '}'
  localparam logic [7:0] CharEight  = 8'h38;  // '8'
  localparam logic [7:0] CharUpperA = 8'h41;  // 'A'
  localparam logic [7:0] CharUpperT = 8'h54;  // 'T'
  localparam logic [7:0] CharUpperE = 8'h45;  // 'E'
  localparam logic [7:0] CharColon  = 8'h3A;  // ':'
  localparam logic [7:0] CharZero   = 8'h30;  // '0'
  localparam logic [7:0] CharOne    = 8'h31;  // '1'

  // Three independent character sets for the first eight prefix positions.
  localparam logic [7:0] AcceptA [8] = '{8'h70, 8'h61, 8'h72, 8'h61,
                                          8'h6D, 8'h73, 8'h22, 8'h3A};
  localparam logic [7:0] AcceptB [8] = '{8'h45, 8'h52, 8'h52, 8'h4F,
                                          8'h52, 8'h3A, 8'h32, 8'h30};
  localparam logic [7:0] AcceptC [8] = '{8'h54, 8'h43, 8'h4D, 8'h51,
                                          8'h54, 8'h54, 8'h53, 8'h54};

  // One-hot parser states.
  typedef enum logic [14:0] {
    ParseP0         = 15'h0001,
    ParseP1         = 15'h0002,
    ParseP2         = 15'h0004,
    ParseP3         = 15'h0008,
    ParseP4         = 15'h0010,
    ParseP5         = 15'h0020,
    ParseP6         = 15'h0040,
    ParseP7         = 15'h0080,
    ParseBranch     = 15'h0100,
    ParseCapture    = 15'h0200,
    ParseError      = 15'h0400,
    ParseStateT     = 15'h0800,
    ParseStateE     = 15'h1000,
    ParseStateColon = 15'h2000,
    ParseStateVal   = 15'h4000
  } parse_state_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       capture_valid;
    logic [7:0] capture_index;
    logic [7:0] capture_byte;
    logic       frame_done;
    logic [8:0] frame_length;
    logic       frame_pending;
    logic       link_up;
    logic       time_sync_drop;
  } out_item_t;

  // Parser context carried from one transfer to the next.
  typedef struct packed {
    parse_state_e      parse;
    logic [CountW-1:0] count;
    logic              pending;
    logic              link;
  } ctx_t;

  function automatic logic prefix_hit(logic [2:0] pos, logic [7:0] b);
    return (b == AcceptA[pos]) || (b == AcceptB[pos]) || (b == AcceptC[pos]);
  endfunction

endpackage

### rtl/core/wifi_response_prefix_parser_core.sv
// ----------------------------------------------------------------------------
// wifi_response_prefix_parser_core
// Byte-serial prefix parser for wifi module responses with frame capture.
// ----------------------------------------------------------------------------
// An input transfer passes through the input register, then the result
// register. Throughput: one transfer per cycle while the output is not
// stalled, set by the parser update between the two registers.
// Reset: rst_ni is asynchronous and active low; it empties both registers,
// returns the parser to idle and clears the count, pending and link flags.
module wifi_response_prefix_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wrpp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wrpp_pkg::out_item_t out_item_o
);
  import wrpp_pkg::*;

  // Input register. It holds one item until the result register has room.
  logic      in_valid_q;
  in_item_t  in_item_q;

  // Result register and the parser context that advances with each item.
  logic      out_valid_q;
  out_item_t out_item_q;
  ctx_t      ctx_q;
  ctx_t      ctx_d;
  out_item_t res_d;

  logic out_load;
  logic in_load;

  // The result register takes the next item whenever it is empty or its
  // current result is being taken in this same cycle.
  assign out_load   = in_valid_q && (!out_valid_q || out_ready_i);
  // The input register frees up whenever its item moves on, so a new
  // transfer can land in every cycle unless the output stalls.
  assign in_ready_o = !in_valid_q || out_load;
  assign in_load    = in_valid_i && in_ready_o;

  wrpp_step u_step (
    .ctx_i  (ctx_q),
    .item_i (in_item_q),
    .ctx_o  (ctx_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_item_q <= in_item_i;
    end
  end

  // The parser context only advances when an item actually reaches the
  // result register, so stalls on the output never lose or repeat a step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.parse   <= ParseP0;
      ctx_q.count   <= '0;
      ctx_q.pending <= 1'b0;
      ctx_q.link    <= 1'b0;
    end else if (out_load) begin
      ctx_q <= ctx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A completed frame always comes with its closing byte captured and the pending flag set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.frame_done |->
      out_item_q.capture_valid && out_item_q.frame_pending)
    else $error("frame_done without capture or pending flag");

  // A time-sync drop always leaves the link down.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.time_sync_drop |-> !out_item_q.link_up)
    else $error("time_sync_drop with link_up set");

  // The capture count saturates at the capture depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_q.count <= CountW'(CaptureDepth))
    else $error("capture count beyond capture depth");

  // Bytes are only captured while the parser sits in the capture state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && res_d.capture_valid |-> ctx_q.parse == ParseCapture)
    else $error("capture outside capture state");

  // The context holds while the item in the input register is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(ctx_q))
    else $error("parser context moved without an item");

endmodule

### rtl/core/wrpp_step.sv
// ----------------------------------------------------------------------------
// wrpp_step
// Next-state and result logic for one received byte or consume request.
// ----------------------------------------------------------------------------
module wrpp_step (
  input  wrpp_pkg::ctx_t     ctx_i,
  input  wrpp_pkg::in_item_t item_i,
  output wrpp_pkg::ctx_t     ctx_o,
  output wrpp_pkg::out_item_t res_o
);
  import wrpp_pkg::*;

  logic [7:0]        b;
  logic [CountW-1:0] sat_idx;
  logic [CountW-1:0] next_count;
  logic              is_term;

  assign b          = item_i.rx_byte;
  assign sat_idx    = (ctx_i.count > CountW'(CaptureDepth - 1)) ?
                      CountW'(CaptureDepth - 1) : ctx_i.count;
  assign next_count = sat_idx + CountW'(1);
  assign is_term    = (b == CharClose) || (b == LineFeed);

  always_comb begin
    logic         in_pfx;
    logic [2:0]   pos;
    parse_state_e pfx_next;
    in_pfx   = 1'b0;
    pos      = 3'd0;
    pfx_next = ParseP1;
    ctx_o    = ctx_i;
    res_o    = '0;

    if (item_i.req_type) begin
      ctx_o.pending = 1'b0;
    end else begin
      unique case (ctx_i.parse)
        ParseP0: begin in_pfx = 1'b1; pos = 3'd0; pfx_next = ParseP1; end
        ParseP1: begin in_pfx = 1'b1; pos = 3'd1; pfx_next = ParseP2; end
        ParseP2: begin in_pfx = 1'b1; pos = 3'd2; pfx_next = ParseP3; end
        ParseP3: begin in_pfx = 1'b1; pos = 3'd3; pfx_next = ParseP4; end
        ParseP4: begin in_pfx = 1'b1; pos = 3'd4; pfx_next = ParseP5; end
        ParseP5: begin in_pfx = 1'b1; pos = 3'd5; pfx_next = ParseP6; end
        ParseP6: begin in_pfx = 1'b1; pos = 3'd6; pfx_next = ParseP7; end
        ParseP7: begin in_pfx = 1'b1; pos = 3'd7; pfx_next = ParseBranch; end
        ParseBranch: begin
          if (b == CharOpen) begin
            ctx_o.parse = ParseCapture;
          end else if (b == CharEight) begin
            ctx_o.parse = ParseError;
          end else if (b == CharUpperA) begin
            ctx_o.parse = ParseStateT;
          end else begin
            ctx_o.parse = ParseP0;
            ctx_o.count = '0;
          end
        end
        ParseCapture: begin
          if (!ctx_i.pending) begin
            res_o.capture_valid = 1'b1;
            res_o.capture_index = 8'(sat_idx);
            res_o.capture_byte  = b;
            ctx_o.count         = next_count;
            if (is_term) begin
              ctx_o.pending      = 1'b1;
              res_o.frame_done   = 1'b1;
              res_o.frame_length = 9'(next_count);
              ctx_o.parse        = ParseP0;
              ctx_o.count        = '0;
            end
          end else begin
            // Previous frame not yet consumed: drop the byte and start over.
            ctx_o.pending = 1'b0;
            ctx_o.parse   = ParseP0;
            ctx_o.count   = '0;
          end
        end
        ParseError: begin
          ctx_o.link           = 1'b0;
          res_o.time_sync_drop = 1'b1;
          ctx_o.parse          = ParseP0;
          ctx_o.count          = '0;
        end
        ParseStateT: begin
          ctx_o.parse = (b == CharUpperT) ? ParseStateE : ParseP0;
          if (b != CharUpperT) ctx_o.count = '0;
        end
        ParseStateE: begin
          ctx_o.parse = (b == CharUpperE) ? ParseStateColon : ParseP0;
          if (b != CharUpperE) ctx_o.count = '0;
        end
        ParseStateColon: begin
          ctx_o.parse = (b == CharColon) ? ParseStateVal : ParseP0;
          if (b != CharColon) ctx_o.count = '0;
        end
        ParseStateVal: begin
          if (b == CharZero) begin
            ctx_o.link           = 1'b0;
            res_o.time_sync_drop = 1'b1;
          end else if (b == CharOne) begin
            ctx_o.link = 1'b1;
          end
          ctx_o.parse = ParseP0;
          ctx_o.count = '0;
        end
        default: begin
          ctx_o.parse = ParseP0;
          ctx_o.count = '0;
        end
      endcase

      if (in_pfx) begin
        if (prefix_hit(pos, b)) begin
          ctx_o.parse = pfx_next;
        end else begin
          ctx_o.parse = ParseP0;
          ctx_o.count = '0;
        end
      end
    end

    res_o.frame_pending = ctx_o.pending;
    res_o.link_up       = ctx_o.link;
  end

endmodule
